// File: src/rcfp_pkg.sv
// Package with the shared types, codes and lookup functions of the frame parser.
package rcfp_pkg;

  // Result queue depth between the parser and the output side.
  localparam int QUEUE_DEPTH = 2;

  // Byte positions inside a frame.
  localparam logic [3:0] POS_IDLE  = 4'd0;
  localparam logic [3:0] POS_TYPE  = 4'd1;
  localparam logic [3:0] POS_BODY  = 4'd2;
  localparam logic [3:0] POS_BODY1 = 4'd3;
  localparam logic [3:0] POS_BODY2 = 4'd4;
  localparam logic [3:0] POS_BODY3 = 4'd5;
  // Bytes of id plus checksum header offset: frame ends at position 4 + body length.
  localparam logic [3:0] POS_TAIL_BASE = 4'd4;

  // Body lengths.
  localparam logic [2:0] LEN_NONE = 3'd0;
  localparam logic [2:0] LEN_ONE_WORD = 3'd2;
  localparam logic [2:0] LEN_TWO_WORDS = 3'd4;

  // Frame type codes.
  localparam logic [7:0] TYPE_HEARTBEAT  = 8'h78;
  localparam logic [7:0] TYPE_IGNORED_A  = 8'h9a;
  localparam logic [7:0] TYPE_IGNORED_B  = 8'h12;
  localparam logic [7:0] TYPE_ANGLE      = 8'h23;
  localparam logic [7:0] TYPE_RATE       = 8'h34;
  localparam logic [7:0] TYPE_WHEELS     = 8'h56;
  localparam logic [7:0] TYPE_IGNORED_C  = 8'hbc;

  localparam logic [7:0] HEAD_RESET = 8'hAA;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_BAD_SUM = 2'd1,
    STATUS_BAD_TYPE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ACT_IGNORED   = 3'd0,
    ACT_HEARTBEAT = 3'd1,
    ACT_ANGLE     = 3'd2,
    ACT_RATE      = 3'd3,
    ACT_WHEELS    = 3'd4
  } action_t;

  // One result item as it travels through the queue.
  typedef struct packed {
    status_t            status;
    logic [7:0]         frame_type;
    logic [15:0]        frame_id;
    action_t            action;
    logic signed [15:0] value_first;
    logic signed [15:0] value_second;
  } result_t;

  // Body length lookup, with a flag for known types.
  typedef struct packed {
    logic       known;
    logic [2:0] len;
  } type_info_t;

  function automatic type_info_t type_info(input logic [7:0] t);
    type_info_t ti;
    ti.known = 1'b1;
    ti.len   = LEN_NONE;
    unique case (t)
      TYPE_HEARTBEAT: ti.len = LEN_NONE;
      TYPE_IGNORED_A, TYPE_IGNORED_B: ti.len = LEN_ONE_WORD;
      TYPE_ANGLE, TYPE_RATE, TYPE_WHEELS, TYPE_IGNORED_C: ti.len = LEN_TWO_WORDS;
      default: ti.known = 1'b0;
    endcase
    return ti;
  endfunction

  function automatic action_t action_of(input logic [7:0] t);
    action_t a;
    unique case (t)
      TYPE_HEARTBEAT: a = ACT_HEARTBEAT;
      TYPE_ANGLE:     a = ACT_ANGLE;
      TYPE_RATE:      a = ACT_RATE;
      TYPE_WHEELS:    a = ACT_WHEELS;
      default:        a = ACT_IGNORED;
    endcase
    return a;
  endfunction

endpackage

// File: src/rcfp_intf.sv
// Handshake interfaces for the received byte channel and the result channel.
interface rcfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface rcfp_result_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [7:0]         frame_type;
  logic [15:0]        frame_id;
  logic [2:0]         action;
  logic signed [15:0] value_first;
  logic signed [15:0] value_second;

  modport source (output valid, output status, output frame_type, output frame_id,
                  output action, output value_first, output value_second, input ready);
  modport sink (input valid, input status, input frame_type, input frame_id,
                input action, input value_first, input value_second, output ready);
endinterface

// File: src/remote_command_frame_parser_top.sv
// Remote command frame parser: byte-wise frame tracker feeding a result queue.
// A result is written into the result queue on the transfer of the byte that ends its frame.
// Throughput: one byte per cycle; input stalls only while the result queue is full.
// The result queue holds QUEUE_DEPTH entries and is the only buffering on the output side.
// Reset (synchronous, rst_n low) returns the parser to idle, empties the queue and
// sets the head byte to 0xAA.
module remote_command_frame_parser_top #(
  parameter int QUEUE_DEPTH = rcfp_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [7:0]    cfg_wdata,
  rcfp_byte_if.sink     in_ch,
  rcfp_result_if.source out_ch
);
  import rcfp_pkg::*;

  logic    queue_full;
  logic    push_valid;
  result_t push_data;

  // Front end: frame tracking and classification.
  rcfp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_byte    (in_ch.rx_byte),
    .queue_full (queue_full),
    .push_valid (push_valid),
    .push_data  (push_data)
  );

  // Back end: result queue and output transfer.
  rcfp_back #(
    .DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .queue_full (queue_full),
    .out_ch     (out_ch)
  );

endmodule

// File: src/rcfp_front.sv
// Frame parser front end: takes bytes, tracks the frame and emits result records.
module rcfp_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [7:0]       cfg_wdata,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_byte,
  input  logic             queue_full,
  output logic             push_valid,
  output rcfp_pkg::result_t push_data
);
  import rcfp_pkg::*;

  logic [7:0]  head_r;
  logic [3:0]  pos_r, pos_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [2:0]  len_r, len_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [15:0] id_r, id_nxt;
  logic [15:0] v1_r, v1_nxt;
  logic [15:0] v2_r, v2_nxt;
  logic        accept;
  type_info_t  ti;

  // Any byte may end a frame, so a transfer needs a free queue slot.
  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;
  assign ti       = type_info(in_byte);

  // Head byte register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= HEAD_RESET;
    end else if (cfg_we) begin
      head_r <= cfg_wdata;
    end
  end

  // Frame tracking state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= POS_IDLE;
      type_r <= '0;
      len_r  <= LEN_NONE;
      sum_r  <= '0;
    end else begin
      pos_r  <= pos_nxt;
      type_r <= type_nxt;
      len_r  <= len_nxt;
      sum_r  <= sum_nxt;
    end
  end

  // Captured id and body words.
  always_ff @(posedge clk) begin
    id_r <= id_nxt;
    v1_r <= v1_nxt;
    v2_r <= v2_nxt;
  end

  // Per-byte update and result building.
  always_comb begin
    pos_nxt    = pos_r;
    type_nxt   = type_r;
    len_nxt    = len_r;
    sum_nxt    = sum_r;
    id_nxt     = id_r;
    v1_nxt     = v1_r;
    v2_nxt     = v2_r;
    push_valid = 1'b0;
    push_data  = '0;
    if (accept) begin
      priority if (pos_r == POS_IDLE) begin
        // Stray bytes outside a frame are dropped.
        if (in_byte == head_r) begin
          pos_nxt = POS_TYPE;
          sum_nxt = in_byte;
        end
      end else if (pos_r == POS_TYPE) begin
        if (!ti.known) begin
          push_valid           = 1'b1;
          push_data.status     = STATUS_BAD_TYPE;
          push_data.frame_type = in_byte;
          pos_nxt  = POS_IDLE;
          type_nxt = '0;
          len_nxt  = LEN_NONE;
          sum_nxt  = '0;
        end else begin
          type_nxt = in_byte;
          len_nxt  = ti.len;
          pos_nxt  = POS_BODY;
          sum_nxt  = sum_r + in_byte;
        end
      end else if (pos_r >= POS_TAIL_BASE + {1'b0, len_r}) begin
        // Checksum byte closes the frame.
        push_valid           = 1'b1;
        push_data.frame_type = type_r;
        if (sum_r == in_byte) begin
          push_data.status   = STATUS_OK;
          push_data.frame_id = id_r;
          push_data.action   = action_of(type_r);
          if (len_r >= LEN_ONE_WORD) begin
            push_data.value_first = v1_r;
          end
          if (len_r >= LEN_TWO_WORDS) begin
            push_data.value_second = v2_r;
          end
        end else begin
          push_data.status = STATUS_BAD_SUM;
        end
        pos_nxt  = POS_IDLE;
        type_nxt = '0;
        len_nxt  = LEN_NONE;
        sum_nxt  = '0;
      end else begin
        // Body and id bytes; the id is the last two bytes before the checksum.
        id_nxt = {id_r[7:0], in_byte};
        if ((pos_r == POS_BODY || pos_r == POS_BODY1) && len_r >= LEN_ONE_WORD) begin
          v1_nxt = {v1_r[7:0], in_byte};
        end
        if ((pos_r == POS_BODY2 || pos_r == POS_BODY3) && len_r >= LEN_TWO_WORDS) begin
          v2_nxt = {v2_r[7:0], in_byte};
        end
        pos_nxt = pos_r + 4'd1;
        sum_nxt = sum_r + in_byte;
      end
    end
  end

endmodule

// File: src/rcfp_back.sv
// Result queue and output side: holds finished results until the sink takes them.
module rcfp_back #(
  parameter int DEPTH = rcfp_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  input  rcfp_pkg::result_t push_data,
  output logic              queue_full,
  rcfp_result_if.source     out_ch
);
  import rcfp_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  result_t          mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             pop;
  result_t          head;

  assign queue_full = (count_r == CNT_FULL);
  assign pop        = out_ch.valid && out_ch.ready;

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push_valid) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_valid) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_valid && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push_valid) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // The oldest entry drives the result channel.
  assign head                = mem[rd_ptr_r];
  assign out_ch.valid        = (count_r != '0);
  assign out_ch.status       = head.status;
  assign out_ch.frame_type   = head.frame_type;
  assign out_ch.frame_id     = head.frame_id;
  assign out_ch.action       = head.action;
  assign out_ch.value_first  = head.value_first;
  assign out_ch.value_second = head.value_second;

endmodule
